FILE: hdl/encoder_position_speed_tracker_defines.svh
// assertion helpers shared by the tracker modules
`ifndef ENCODER_POSITION_SPEED_TRACKER_DEFINES_SVH
`define ENCODER_POSITION_SPEED_TRACKER_DEFINES_SVH

// clocked check, quiet while reset is applied
`define EPST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define EPST_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/epst_pkg.sv
`default_nettype none
package epst_pkg;

    localparam int COUNTER_BITS_DEF = 16;

    // configuration register widths
    localparam int MOD_W   = 17;
    localparam int CPR_W   = 19;
    localparam int GAIN_W  = 32;
    localparam int ALPHA_W = 16;
    localparam int PP_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CPR_W-1:0] CPR_MIN = 19'd4;
    localparam logic [CPR_W-1:0] CPR_MAX = 19'd262144;
    localparam logic [MOD_W-1:0] MOD_MIN = 17'd2;

    localparam logic [MOD_W-1:0]     MOD_RST   = 17'd65536;
    localparam logic [CPR_W-1:0]     CPR_RST   = 19'd4096;
    localparam logic [GAIN_W-1:0]    GAIN_RST  = 32'd65536;
    localparam logic [ALPHA_W-1:0]   ALPHA_RST = 16'd62259;
    localparam logic [PP_W-1:0]      PP_RST    = 8'd1;

    // shared unit widths
    localparam int DIVD_W  = 48;
    localparam int DVSR_W  = 33;
    localparam int MULA_W  = 32;
    localparam int MULB_W  = 32;
    localparam int PROD_W  = 64;
    localparam int STEP_W  = 6;
    localparam int DIV_STEPS = 48;
    localparam int MUL_STEPS = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 3'd0,
        CFG_CPR     = 3'd1,
        CFG_DIR     = 3'd2,
        CFG_GAIN    = 3'd3,
        CFG_ALPHA   = 3'd4,
        CFG_POLES   = 3'd5
    } cfg_index_t;

    typedef enum logic {
        AU_MUL = 1'b0,
        AU_DIV = 1'b1
    } au_op_t;

    typedef struct packed {
        logic   start;
        au_op_t op;
    } au_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } au_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CNT,
        ST_PRE,
        ST_IDX,
        ST_LST,
        ST_DELTA,
        ST_POS,
        ST_MRAW,
        ST_MY,
        ST_MR,
        ST_FILT,
        ST_ANG,
        ST_M,
        ST_MECH0,
        ST_MECH,
        ST_MPP,
        ST_ELEC,
        ST_OUT
    } state_t;

endpackage
`default_nettype wire

FILE: hdl/epst_if.sv
`default_nettype none
interface epst_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [15:0]        counter_value;
    logic               index_flag;
    logic signed [31:0] preset_position;

    modport source (output valid, mode, counter_value, index_flag, preset_position,
                    input ready);
    modport sink   (input valid, mode, counter_value, index_flag, preset_position,
                    output ready);
endinterface

interface epst_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position_count;
    logic [15:0]        mech_angle;
    logic [15:0]        elec_angle;
    logic signed [31:0] speed;
    logic signed [31:0] drift_count;
    logic               index_seen;

    modport source (output valid, position_count, mech_angle, elec_angle, speed,
                    drift_count, index_seen, input ready);
    modport sink   (input valid, position_count, mech_angle, elec_angle, speed,
                    drift_count, index_seen, output ready);
endinterface
`default_nettype wire

FILE: hdl/encoder_position_speed_tracker.sv
// each item runs its divisions and multiplications one at a time on the shared unit, with
// sequencer steps between them, before its result reaches the output register
// one item at a time: the next item is taken only once the last result is registered, later while a result waits
// reset: asynchronous, active low; tracker state clears to zero, configuration returns to defaults
`default_nettype none
`include "encoder_position_speed_tracker_defines.svh"
module encoder_position_speed_tracker
    import epst_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    epst_in_if.sink                    in_ch,
    epst_out_if.source                 out_ch
);

    // counter width bounds the usable modulus and masks the raw counter
    localparam int          COUNTER_BITS = COUNTER_BITS_DEF;
    localparam logic [32:0] MOD_TOP = 33'(1) << COUNTER_BITS;
    localparam logic [15:0] CMASK   = (COUNTER_BITS >= 16) ? 16'hFFFF
                                    : 16'((17'(1) << COUNTER_BITS) - 17'd1);
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // configuration
    logic [MOD_W-1:0]   cfg_mod_reg;
    logic [CPR_W-1:0]   cfg_cpr_reg;
    logic               cfg_dir_reg;
    logic [GAIN_W-1:0]  cfg_gain_reg;
    logic [ALPHA_W-1:0] cfg_alpha_reg;
    logic [PP_W-1:0]    cfg_pp_reg;

    // sequencer and shared unit hand-over
    state_t             state_reg, state_next;
    logic               start_reg, start_next;
    au_op_t             op_reg, op_next;
    logic [DIVD_W-1:0]  opa_reg, opa_next;
    logic [DVSR_W-1:0]  opb_reg, opb_next;
    au_req_t            au_req;
    au_rsp_t            au_rsp;
    logic [PROD_W-1:0]  au_res;
    logic [DVSR_W-1:0]  au_rem;

    // tracker state
    logic [15:0]        last_reg, last_next;
    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        ref_reg, ref_next;
    logic               rec_reg, rec_next;
    logic [31:0]        drift_reg, drift_next;
    logic [31:0]        filt_reg, filt_next;

    // per item work registers
    logic               mode_reg, mode_next;
    logic               index_reg, index_next;
    logic [31:0]        preset_reg, preset_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [15:0]        lst_reg, lst_next;
    logic [31:0]        rel_reg, rel_next;
    logic signed [17:0] delta_reg, delta_next;
    logic [31:0]        raw_reg, raw_next;
    logic signed [51:0] aterm_reg, aterm_next;
    logic signed [51:0] acc_reg, acc_next;
    logic [17:0]        m_reg, m_next;
    logic [15:0]        mech_reg, mech_next;
    logic [15:0]        elec_reg, elec_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        o_pos_reg, o_pos_next;
    logic [15:0]        o_mech_reg, o_mech_next;
    logic [15:0]        o_elec_reg, o_elec_next;
    logic [31:0]        o_speed_reg, o_speed_next;
    logic [31:0]        o_drift_reg, o_drift_next;
    logic               o_seen_reg, o_seen_next;

    // effective limits after saturation
    logic [MOD_W-1:0]   mod_eff;
    logic [CPR_W-1:0]   cpr_eff;

    // datapath helpers
    logic signed [17:0] d_raw, d_wrap, d_dir, half_s, mod_s;
    logic [17:0]        delta_mag;
    logic [31:0]        raw_c;
    logic signed [51:0] a_mag, b_mag, aterm_c, bterm_c;
    logic signed [35:0] q_c;
    logic [31:0]        q_sat;
    logic [CPR_W-1:0]   rem_cpr, m_c;
    logic [31:0]        drift_c;
    logic [MOD_W-1:0]   rem_mod;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        abs32 = x[31] ? (~x + 32'd1) : x;
    endfunction

    always_comb
    begin
        if (cfg_mod_reg < MOD_MIN)
        begin
            mod_eff = MOD_MIN;
        end
        else if ({16'b0, cfg_mod_reg} > MOD_TOP)
        begin
            mod_eff = MOD_TOP[MOD_W-1:0];
        end
        else
        begin
            mod_eff = cfg_mod_reg;
        end
    end

    always_comb
    begin
        if (cfg_cpr_reg < CPR_MIN)
        begin
            cpr_eff = CPR_MIN;
        end
        else if (cfg_cpr_reg > CPR_MAX)
        begin
            cpr_eff = CPR_MAX;
        end
        else
        begin
            cpr_eff = cfg_cpr_reg;
        end
    end

    // count delta unwrapped about half the modulus
    assign d_raw  = $signed({2'b00, cnt_reg}) - $signed({2'b00, lst_reg});
    assign half_s = $signed({2'b00, mod_eff[MOD_W-1:1]});
    assign mod_s  = $signed({1'b0, mod_eff});

    always_comb
    begin
        if (d_raw > half_s)
        begin
            d_wrap = d_raw - mod_s;
        end
        else if (d_raw < -half_s)
        begin
            d_wrap = d_raw + mod_s;
        end
        else
        begin
            d_wrap = d_raw;
        end
        d_dir = cfg_dir_reg ? -d_wrap : d_wrap;
    end

    assign delta_mag = delta_reg[17] ? 18'(-delta_reg) : 18'(delta_reg);

    // raw speed, saturated to signed 32 bits
    always_comb
    begin
        if (!delta_reg[17])
        begin
            raw_c = (au_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : au_res[31:0];
        end
        else
        begin
            raw_c = (au_res > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - au_res[31:0]);
        end
    end

    // filter terms carry the sign of their speed operand
    assign a_mag   = $signed({4'b0, au_res[47:0]});
    assign b_mag   = $signed({3'b0, au_res[48:0]});
    assign aterm_c = filt_reg[31] ? -a_mag : a_mag;
    assign bterm_c = raw_reg[31] ? -b_mag : b_mag;

    // rounded result is floor of the shifted sum
    assign q_c   = acc_reg[51:16];
    assign q_sat = (q_c > $signed(36'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                 : (q_c < $signed(36'hF_8000_0000)) ? 32'h8000_0000
                 : q_c[31:0];

    assign rem_cpr = au_rem[CPR_W-1:0];
    assign rem_mod = au_rem[MOD_W-1:0];
    assign m_c     = (pos_reg[31] && (rem_cpr != '0)) ? (cpr_eff - rem_cpr) : rem_cpr;
    assign drift_c = rel_reg[31] ? (32'd0 - {13'b0, rem_cpr}) : {13'b0, rem_cpr};

    assign au_req.start = start_reg;
    assign au_req.op    = op_reg;

    epst_arith_unit u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (au_req),
        .a         (opa_reg),
        .b         (opb_reg),
        .rsp       (au_rsp),
        .result    (au_res),
        .remainder (au_rem)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        op_next        = op_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        ref_next       = ref_reg;
        rec_next       = rec_reg;
        drift_next     = drift_reg;
        filt_next      = filt_reg;
        mode_next      = mode_reg;
        index_next     = index_reg;
        preset_next    = preset_reg;
        cnt_next       = cnt_reg;
        lst_next       = lst_reg;
        rel_next       = rel_reg;
        delta_next     = delta_reg;
        raw_next       = raw_reg;
        aterm_next     = aterm_reg;
        acc_next       = acc_reg;
        m_next         = m_reg;
        mech_next      = mech_reg;
        elec_next      = elec_reg;
        out_valid_next = out_valid_reg;
        o_pos_next     = o_pos_reg;
        o_mech_next    = o_mech_reg;
        o_elec_next    = o_elec_reg;
        o_speed_next   = o_speed_reg;
        o_drift_next   = o_drift_reg;
        o_seen_next    = o_seen_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    mode_next   = in_ch.mode;
                    index_next  = in_ch.index_flag;
                    preset_next = in_ch.preset_position;
                    opa_next    = {32'b0, in_ch.counter_value & CMASK};
                    opb_next    = {16'b0, mod_eff};
                    op_next     = AU_DIV;
                    start_next  = 1'b1;
                    state_next  = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (au_rsp.done)
                begin
                    cnt_next = au_rem[15:0];
                    priority if (mode_reg)
                    begin
                        opa_next   = {16'b0, abs32(preset_reg)};
                        opb_next   = {16'b0, mod_eff};
                        op_next    = AU_DIV;
                        start_next = 1'b1;
                        state_next = ST_PRE;
                    end
                    else if (index_reg && !rec_reg)
                    begin
                        // first index only records the reference
                        ref_next   = pos_reg;
                        rec_next   = 1'b1;
                        drift_next = '0;
                        last_next  = au_rem[15:0];
                        state_next = ST_ANG;
                    end
                    else if (index_reg)
                    begin
                        rel_next   = pos_reg - ref_reg;
                        opa_next   = {16'b0, abs32(pos_reg - ref_reg)};
                        opb_next   = {14'b0, cpr_eff};
                        op_next    = AU_DIV;
                        start_next = 1'b1;
                        state_next = ST_IDX;
                    end
                    else
                    begin
                        opa_next   = {32'b0, last_reg};
                        opb_next   = {16'b0, mod_eff};
                        op_next    = AU_DIV;
                        start_next = 1'b1;
                        state_next = ST_LST;
                    end
                end
            end
            ST_PRE:
            begin
                if (au_rsp.done)
                begin
                    pos_next   = preset_reg;
                    last_next  = (preset_reg[31] && (rem_mod != '0))
                               ? 16'(mod_eff - rem_mod) : rem_mod[15:0];
                    state_next = ST_ANG;
                end
            end
            ST_IDX:
            begin
                if (au_rsp.done)
                begin
                    // snap to whole revolutions, truncated toward zero
                    drift_next = drift_c;
                    pos_next   = pos_reg - drift_c;
                    last_next  = cnt_reg;
                    state_next = ST_ANG;
                end
            end
            ST_LST:
            begin
                if (au_rsp.done)
                begin
                    lst_next   = au_rem[15:0];
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                delta_next = d_dir;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                pos_next   = pos_reg + {{14{delta_reg[17]}}, delta_reg};
                last_next  = cnt_reg;
                opa_next   = {30'b0, delta_mag};
                opb_next   = {1'b0, cfg_gain_reg};
                op_next    = AU_MUL;
                start_next = 1'b1;
                state_next = ST_MRAW;
            end
            ST_MRAW:
            begin
                if (au_rsp.done)
                begin
                    raw_next   = raw_c;
                    opa_next   = {16'b0, abs32(filt_reg)};
                    opb_next   = {17'b0, cfg_alpha_reg};
                    op_next    = AU_MUL;
                    start_next = 1'b1;
                    state_next = ST_MY;
                end
            end
            ST_MY:
            begin
                if (au_rsp.done)
                begin
                    aterm_next = aterm_c;
                    opa_next   = {16'b0, abs32(raw_reg)};
                    opb_next   = {16'b0, ONE_Q16 - {1'b0, cfg_alpha_reg}};
                    op_next    = AU_MUL;
                    start_next = 1'b1;
                    state_next = ST_MR;
                end
            end
            ST_MR:
            begin
                if (au_rsp.done)
                begin
                    acc_next   = aterm_reg + bterm_c + 52'sd32768;
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                filt_next  = q_sat;
                state_next = ST_ANG;
            end
            ST_ANG:
            begin
                opa_next   = {16'b0, abs32(pos_reg)};
                opb_next   = {14'b0, cpr_eff};
                op_next    = AU_DIV;
                start_next = 1'b1;
                state_next = ST_M;
            end
            ST_M:
            begin
                if (au_rsp.done)
                begin
                    m_next     = m_c[17:0];
                    state_next = ST_MECH0;
                end
            end
            ST_MECH0:
            begin
                opa_next   = {14'b0, m_reg, 16'b0};
                opb_next   = {14'b0, cpr_eff};
                op_next    = AU_DIV;
                start_next = 1'b1;
                state_next = ST_MECH;
            end
            ST_MECH:
            begin
                if (au_rsp.done)
                begin
                    mech_next  = au_res[15:0];
                    opa_next   = {30'b0, m_reg};
                    opb_next   = {25'b0, cfg_pp_reg};
                    op_next    = AU_MUL;
                    start_next = 1'b1;
                    state_next = ST_MPP;
                end
            end
            ST_MPP:
            begin
                if (au_rsp.done)
                begin
                    opa_next   = {6'b0, au_res[25:0], 16'b0};
                    opb_next   = {14'b0, cpr_eff};
                    op_next    = AU_DIV;
                    start_next = 1'b1;
                    state_next = ST_ELEC;
                end
            end
            ST_ELEC:
            begin
                if (au_rsp.done)
                begin
                    elec_next  = au_res[15:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    o_pos_next     = pos_reg;
                    o_mech_next    = mech_reg;
                    o_elec_next    = elec_reg;
                    o_speed_next   = filt_reg;
                    o_drift_next   = drift_reg;
                    o_seen_next    = rec_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mod_reg   <= MOD_RST;
            cfg_cpr_reg   <= CPR_RST;
            cfg_dir_reg   <= 1'b0;
            cfg_gain_reg  <= GAIN_RST;
            cfg_alpha_reg <= ALPHA_RST;
            cfg_pp_reg    <= PP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MODULUS: cfg_mod_reg   <= cfg_data[MOD_W-1:0];
                CFG_CPR:     cfg_cpr_reg   <= cfg_data[CPR_W-1:0];
                CFG_DIR:     cfg_dir_reg   <= cfg_data[0];
                CFG_GAIN:    cfg_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_ALPHA:   cfg_alpha_reg <= cfg_data[ALPHA_W-1:0];
                CFG_POLES:   cfg_pp_reg    <= cfg_data[PP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            pos_reg       <= '0;
            ref_reg       <= '0;
            rec_reg       <= 1'b0;
            drift_reg     <= '0;
            filt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            pos_reg       <= pos_next;
            ref_reg       <= ref_next;
            rec_reg       <= rec_next;
            drift_reg     <= drift_next;
            filt_reg      <= filt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        mode_reg    <= mode_next;
        index_reg   <= index_next;
        preset_reg  <= preset_next;
        cnt_reg     <= cnt_next;
        lst_reg     <= lst_next;
        rel_reg     <= rel_next;
        delta_reg   <= delta_next;
        raw_reg     <= raw_next;
        aterm_reg   <= aterm_next;
        acc_reg     <= acc_next;
        m_reg       <= m_next;
        mech_reg    <= mech_next;
        elec_reg    <= elec_next;
        o_pos_reg   <= o_pos_next;
        o_mech_reg  <= o_mech_next;
        o_elec_reg  <= o_elec_next;
        o_speed_reg <= o_speed_next;
        o_drift_reg <= o_drift_next;
        o_seen_reg  <= o_seen_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.position_count = o_pos_reg;
    assign out_ch.mech_angle     = o_mech_reg;
    assign out_ch.elec_angle     = o_elec_reg;
    assign out_ch.speed          = o_speed_reg;
    assign out_ch.drift_count    = o_drift_reg;
    assign out_ch.index_seen     = o_seen_reg;

    `EPST_ASSERT(a_accept_starts_unit, (in_ch.valid && in_ch.ready) |=> start_reg,
                 "accepted item did not start the shared unit")
    `EPST_NEVER(a_done_outside_run, au_rsp.done && (state_reg == ST_IDLE || state_reg == ST_OUT),
                "shared unit finished outside a waiting state")
    `EPST_NEVER(a_index_sticky, $fell(rec_reg), "index record cleared without reset")

endmodule
`default_nettype wire

FILE: hdl/epst_arith_unit.sv
`default_nettype none
`include "encoder_position_speed_tracker_defines.svh"
module epst_arith_unit
    import epst_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire au_req_t           req,
    input  wire logic [DIVD_W-1:0] a,
    input  wire logic [DVSR_W-1:0] b,
    output au_rsp_t                rsp,
    output logic [PROD_W-1:0]      result,
    output logic [DVSR_W-1:0]      remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    au_op_t            op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] mcand_reg, mcand_next;
    logic [MULB_W-1:0] mplier_reg, mplier_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvsr_reg, dvsr_next;

    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   rem_diff;
    logic              fits;
    logic              last_step;

    assign rem_sh   = {rem_reg, quo_reg[DIVD_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};
    assign fits     = rem_sh >= {1'b0, dvsr_reg};
    assign last_step = (op_reg == AU_DIV) ? (step_reg == STEP_W'(DIV_STEPS - 1))
                                          : (step_reg == STEP_W'(MUL_STEPS - 1));

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            op_next     = req.op;
            step_next   = '0;
            acc_next    = '0;
            mcand_next  = {{(PROD_W-MULA_W){1'b0}}, a[MULA_W-1:0]};
            mplier_next = b[MULB_W-1:0];
            quo_next    = a;
            rem_next    = '0;
            dvsr_next   = b;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + STEP_W'(1);
            if (op_reg == AU_MUL)
            begin
                // shift-add, one multiplier bit a cycle
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PROD_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MULB_W-1:1]};
            end
            else
            begin
                // restoring division, one quotient bit a cycle
                rem_next = fits ? rem_diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], fits};
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= AU_MUL;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign result    = (op_reg == AU_DIV) ? {{(PROD_W-DIVD_W){1'b0}}, quo_reg} : acc_reg;
    assign remainder = rem_reg;

    `EPST_ASSERT(a_start_when_free, req.start |-> !busy_reg, "unit started while busy")
    `EPST_ASSERT(a_done_ends_run, done_reg |-> !busy_reg, "done raised while still busy")
    `EPST_ASSERT(a_run_continues, (busy_reg && !last_step && !req.start) |=> busy_reg,
                 "run stopped early")

endmodule
`default_nettype wire
